/* hw/rtl/camera_parallel_frame_capture_top_macros.svh */
// Assertion macros for the checker file of the frame capture block.
`ifndef CAMERA_PARALLEL_FRAME_CAPTURE_TOP_MACROS_SVH
`define CAMERA_PARALLEL_FRAME_CAPTURE_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define DVPC_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dvpc checker: same-cycle rule violated");

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define DVPC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dvpc checker: next-cycle rule violated");

`endif

/* hw/rtl/dvpc_pkg.sv */
`default_nettype none

package dvpc_pkg;

  localparam int unsigned DataW    = 8;
  localparam int unsigned LimitW   = 21;
  localparam int unsigned TimeoutW = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] CfgIdxMode    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxLimit   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgIdxTimeout = 2'd2;

  localparam logic [LimitW-1:0]   LimitReset   = 21'd153600;
  localparam logic [TimeoutW-1:0] TimeoutReset = 32'd1000000;

  // JPEG end-of-image marker bytes.
  localparam logic [DataW-1:0] MarkFf = 8'hFF;
  localparam logic [DataW-1:0] MarkD9 = 8'hD9;

  typedef struct packed {
    logic             kind;
    logic             vsync;
    logic             href;
    logic             pclk;
    logic [DataW-1:0] data;
  } sample_t;

  typedef struct packed {
    logic                capture_mode;
    logic [LimitW-1:0]   byte_limit;
    logic [TimeoutW-1:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic              byte_valid;
    logic [DataW-1:0]  pixel_byte;
    logic              done_res;
    logic              status;
    logic [LimitW-1:0] frame_length;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/dvpc_cfg.sv */
`default_nettype none

module dvpc_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [dvpc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [dvpc_pkg::CfgDataW-1:0] cfg_data_i,
  output      dvpc_pkg::cfg_t                cfg_o
);

  dvpc_pkg::cfg_t cfg_d, cfg_q;

  assign cfg_ready_o = 1'b1;

  // Writes to an index outside the register list are taken and dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        dvpc_pkg::CfgIdxMode:    cfg_d.capture_mode  = cfg_data_i[0];
        dvpc_pkg::CfgIdxLimit:   cfg_d.byte_limit    = cfg_data_i[dvpc_pkg::LimitW-1:0];
        dvpc_pkg::CfgIdxTimeout: cfg_d.timeout_ticks = cfg_data_i[dvpc_pkg::TimeoutW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.capture_mode  <= 1'b0;
      cfg_q.byte_limit    <= dvpc_pkg::LimitReset;
      cfg_q.timeout_ticks <= dvpc_pkg::TimeoutReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* hw/rtl/dvpc_in_reg.sv */
`default_nettype none

module dvpc_in_reg (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output      logic            in_ready_o,
  input  wire dvpc_pkg::sample_t sample_i,
  input  wire logic            take_i,
  output      logic            valid_o,
  output      dvpc_pkg::sample_t sample_o
);

  logic              valid_d, valid_q;
  dvpc_pkg::sample_t sample_q;

  // The slot refills in the same cycle that the core consumes it.
  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sample_q <= sample_i;
    end
  end

  assign valid_o  = valid_q;
  assign sample_o = sample_q;

endmodule

`default_nettype wire

/* hw/rtl/dvpc_core.sv */
`default_nettype none

module dvpc_core #(
  parameter int unsigned MAX_FRAME_BYTES = 1048576
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire dvpc_pkg::sample_t sample_i,
  input  wire dvpc_pkg::cfg_t    cfg_i,
  output      logic              take_o,
  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  output      dvpc_pkg::result_t result_o
);

  localparam int unsigned LimitW   = dvpc_pkg::LimitW;
  localparam int unsigned TimeoutW = dvpc_pkg::TimeoutW;

  localparam logic [2:0] PhIdle    = 3'd0;
  localparam logic [2:0] PhVsLow   = 3'd1;
  localparam logic [2:0] PhVsRise  = 3'd2;
  localparam logic [2:0] PhHrefLow = 3'd3;
  localparam logic [2:0] PhTake    = 3'd4;

  localparam logic [31:0]       MaxBytes32 = 32'(MAX_FRAME_BYTES);
  localparam logic [LimitW-1:0] MaxLimit   = LimitW'(MAX_FRAME_BYTES);

  logic [2:0]          phase_d, phase_q;
  logic [LimitW-1:0]   bytes_d, bytes_q;
  logic [LimitW-1:0]   marker_d, marker_q;
  logic                prev_ff_d, prev_ff_q;
  logic [TimeoutW-1:0] wait_d, wait_q;
  logic                pclk_low_d, pclk_low_q;
  logic                run_mode_d, run_mode_q;
  logic [LimitW-1:0]   run_limit_d, run_limit_q;

  logic                out_valid_d, out_valid_q;
  logic                emit;
  dvpc_pkg::result_t   res_d, res_q;

  logic [TimeoutW-1:0] wait_inc;
  logic                wait_expired;
  logic [LimitW-1:0]   bytes_inc;
  logic [LimitW-1:0]   marker_new;
  logic [LimitW-1:0]   trim_len;
  logic [LimitW-1:0]   trim_len_new;
  logic                pclk_low_eff;
  logic                byte_hit;
  logic [LimitW-1:0]   limit_clamped;

  // The core works on the held item only when the result slot can take
  // whatever that item produces.
  assign take_o = valid_i && (!out_valid_q || out_ready_i);

  assign wait_inc     = wait_q + 1'b1;
  assign wait_expired = (wait_inc >= cfg_i.timeout_ticks);
  assign bytes_inc    = bytes_q + 1'b1;
  assign trim_len     = (marker_q != '0) ? marker_q : bytes_q;
  assign pclk_low_eff = pclk_low_q || !sample_i.pclk;
  assign byte_hit     = sample_i.href && sample_i.pclk && pclk_low_eff;
  assign marker_new   = (prev_ff_q && (sample_i.data == dvpc_pkg::MarkD9)) ? bytes_inc
                                                                          : marker_q;
  assign trim_len_new = (marker_new != '0) ? marker_new : bytes_inc;

  always_comb begin
    if (cfg_i.byte_limit == '0) begin
      limit_clamped = LimitW'(1);
    end else if (32'(cfg_i.byte_limit) > MaxBytes32) begin
      limit_clamped = MaxLimit;
    end else begin
      limit_clamped = cfg_i.byte_limit;
    end
  end

  always_comb begin
    phase_d     = phase_q;
    bytes_d     = bytes_q;
    marker_d    = marker_q;
    prev_ff_d   = prev_ff_q;
    wait_d      = wait_q;
    pclk_low_d  = pclk_low_q;
    run_mode_d  = run_mode_q;
    run_limit_d = run_limit_q;
    emit        = 1'b0;
    res_d       = '0;

    if (sample_i.kind) begin
      run_mode_d  = cfg_i.capture_mode;
      run_limit_d = limit_clamped;
      bytes_d     = '0;
      marker_d    = '0;
      prev_ff_d   = 1'b0;
      pclk_low_d  = 1'b0;
      phase_d     = PhVsLow;
      wait_d      = '0;
    end else begin
      unique case (phase_q) inside
        PhVsLow, PhVsRise, PhHrefLow: begin
          if ((phase_q == PhVsLow) && !sample_i.vsync) begin
            phase_d = PhVsRise;
            wait_d  = '0;
          end else if ((phase_q == PhVsRise) && sample_i.vsync) begin
            pclk_low_d = 1'b1;
            phase_d    = run_mode_q ? PhTake : PhHrefLow;
            wait_d     = '0;
          end else if ((phase_q == PhHrefLow) && !sample_i.href) begin
            pclk_low_d = 1'b1;
            phase_d    = PhTake;
            wait_d     = '0;
          end else begin
            wait_d = wait_inc;
            if (wait_expired) begin
              phase_d      = PhIdle;
              emit         = 1'b1;
              res_d.done_res = 1'b1;
              res_d.status   = 1'b1;
            end
          end
        end
        PhTake: begin
          if (run_mode_q && !sample_i.vsync) begin
            // VSYNC fall closes a continuous frame; this sample holds no byte.
            phase_d            = PhIdle;
            emit               = 1'b1;
            res_d.done_res     = 1'b1;
            res_d.frame_length = trim_len;
          end else if (byte_hit) begin
            pclk_low_d       = 1'b0;
            bytes_d          = bytes_inc;
            marker_d         = marker_new;
            prev_ff_d        = (sample_i.data == dvpc_pkg::MarkFf);
            emit             = 1'b1;
            res_d.byte_valid = 1'b1;
            res_d.pixel_byte = sample_i.data;
            if (bytes_inc >= run_limit_q) begin
              phase_d            = PhIdle;
              res_d.done_res     = 1'b1;
              res_d.frame_length = run_mode_q ? trim_len_new : bytes_inc;
            end else begin
              wait_d = wait_inc;
              if (wait_expired) begin
                phase_d        = PhIdle;
                res_d.done_res = 1'b1;
                res_d.status   = 1'b1;
              end
            end
          end else begin
            pclk_low_d = pclk_low_eff;
            wait_d     = wait_inc;
            if (wait_expired) begin
              phase_d        = PhIdle;
              emit           = 1'b1;
              res_d.done_res = 1'b1;
              res_d.status   = 1'b1;
            end
          end
        end
        default: begin
          phase_d = PhIdle;
        end
      endcase
    end
  end

  assign out_valid_d = take_o ? emit : (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      bytes_q     <= '0;
      marker_q    <= '0;
      prev_ff_q   <= 1'b0;
      wait_q      <= '0;
      pclk_low_q  <= 1'b0;
      run_mode_q  <= 1'b0;
      run_limit_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take_o) begin
        phase_q     <= phase_d;
        bytes_q     <= bytes_d;
        marker_q    <= marker_d;
        prev_ff_q   <= prev_ff_d;
        wait_q      <= wait_d;
        pclk_low_q  <= pclk_low_d;
        run_mode_q  <= run_mode_d;
        run_limit_q <= run_limit_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

endmodule

`default_nettype wire

/* hw/rtl/camera_parallel_frame_capture_top.sv */
// Parallel camera bus frame capture.
// The input channel (in_valid_i / in_ready_o) carries one item per sample of
// the camera pins, or an arm item (kind_i high) that starts a new capture with
// the mode and byte limit held in the configuration registers at that moment.
// The output channel (out_valid_o / out_ready_i) carries a result only for
// items that take a byte or end the capture; other items produce nothing.
// The configuration port (cfg_valid_i / cfg_ready_o) writes register
// cfg_index_i with cfg_data_i: 0 capture mode, 1 byte limit, 2 timeout.
// It is always ready and should only be written while no capture runs.
// Throughput is one item per clock while no result stalls. An item is held in
// the input register and its result is then stored in the output register.
// When the receiver stalls, the result is held and one more item waits in the
// input register; in_ready_o then drops until the result is taken.
// Reset clears the capture state to idle, empties both registers and loads the
// register defaults (sized mode, 153600 bytes, 1000000 sample timeout).
`default_nettype none

module camera_parallel_frame_capture_top #(
  parameter int unsigned MAX_FRAME_BYTES = 1048576
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic                          kind_i,
  input  wire logic                          vsync_i,
  input  wire logic                          href_i,
  input  wire logic                          pclk_i,
  input  wire logic [dvpc_pkg::DataW-1:0]    pixel_data_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic                          byte_valid_o,
  output      logic [dvpc_pkg::DataW-1:0]    pixel_byte_o,
  output      logic                          done_res_o,
  output      logic                          status_o,
  output      logic [dvpc_pkg::LimitW-1:0]   frame_length_o,
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [dvpc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [dvpc_pkg::CfgDataW-1:0] cfg_data_i
);

  dvpc_pkg::sample_t sample_in;
  dvpc_pkg::sample_t sample_held;
  dvpc_pkg::cfg_t    cfg;
  dvpc_pkg::result_t result;
  logic              held_valid;
  logic              take;

  assign sample_in.kind  = kind_i;
  assign sample_in.vsync = vsync_i;
  assign sample_in.href  = href_i;
  assign sample_in.pclk  = pclk_i;
  assign sample_in.data  = pixel_data_i;

  dvpc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dvpc_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sample_i   (sample_in),
    .take_i     (take),
    .valid_o    (held_valid),
    .sample_o   (sample_held)
  );

  // The core holds the capture state and the result register.
  dvpc_core #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (held_valid),
    .sample_i    (sample_held),
    .cfg_i       (cfg),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result)
  );

  assign byte_valid_o   = result.byte_valid;
  assign pixel_byte_o   = result.pixel_byte;
  assign done_res_o     = result.done_res;
  assign status_o       = result.status;
  assign frame_length_o = result.frame_length;

endmodule

`default_nettype wire

/* hw/rtl/dvpc_checker.sv */
`default_nettype none

`include "camera_parallel_frame_capture_top_macros.svh"

module dvpc_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire logic                        byte_valid_o,
  input wire logic [dvpc_pkg::DataW-1:0]  pixel_byte_o,
  input wire logic                        done_res_o,
  input wire logic                        status_o,
  input wire logic [dvpc_pkg::LimitW-1:0] frame_length_o
);

  // A timeout is always the end of the capture.
  `DVPC_ASSERT_NOW(a_status_needs_done, out_valid_o && status_o, done_res_o)

  // A length is reported only on a completed frame.
  `DVPC_ASSERT_NOW(a_length_on_complete, out_valid_o && (frame_length_o != '0),
                   done_res_o && !status_o)

  // Every result either carries a byte or ends the capture.
  `DVPC_ASSERT_NOW(a_result_has_content, out_valid_o, byte_valid_o || done_res_o)

  // A stalled result stays put.
  `DVPC_ASSERT_NEXT(a_stall_holds, out_valid_o && !out_ready_i,
                    out_valid_o && $stable(pixel_byte_o) && $stable(frame_length_o))

endmodule

bind camera_parallel_frame_capture_top dvpc_checker u_dvpc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .byte_valid_o   (byte_valid_o),
  .pixel_byte_o   (pixel_byte_o),
  .done_res_o     (done_res_o),
  .status_o       (status_o),
  .frame_length_o (frame_length_o)
);

`default_nettype wire
